@@ hdl/spq_pkg.sv @@
package spq_pkg;

   localparam int DEPTH = 64;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int LIM_W = 7;
   localparam int CMP_W = (CW > LIM_W) ? CW : LIM_W;
   localparam int DW    = 32;

   localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd64;
   localparam logic             KIND_ENQ    = 1'b0;
   localparam logic             KIND_DEQ    = 1'b1;

   typedef logic [AW-1:0] addr_type;
   typedef logic [CW-1:0] count_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEQ,
      S_SCAN,
      S_PLACE,
      S_FIN
   } state_type;

   typedef struct packed {
      logic signed [DW-1:0] prio;
      logic signed [DW-1:0] value;
   } entry_type;

   typedef struct packed {
      status_type           status;
      logic signed [DW-1:0] head_value;
      count_type            count;
   } result_type;

   function automatic addr_type addr_inc(addr_type a);
      addr_type r;
      if (a == addr_type'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = a + addr_type'(1);
      end
      return r;
   endfunction

   function automatic addr_type addr_dec(addr_type a);
      addr_type r;
      if (a == '0) begin
         r = addr_type'(DEPTH - 1);
      end else begin
         r = a - addr_type'(1);
      end
      return r;
   endfunction

endpackage

@@ hdl/spq_ram.sv @@
module spq_ram #(
   parameter int ADDR_W = 6,
   parameter int DATA_W = 64,
   parameter int WORDS  = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/spq_ctrl.sv @@
module spq_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic signed [spq_pkg::DW-1:0]  req_value,
   input  logic signed [spq_pkg::DW-1:0]  req_prio,
   input  logic [spq_pkg::LIM_W-1:0]      limit,
   output logic                           res_valid,
   input  logic                           res_ready,
   output spq_pkg::result_type            res
);
   import spq_pkg::*;

   state_type  state_ff,  state_in;
   addr_type   head_ff,   head_in;
   addr_type   tail_ff,   tail_in;
   count_type  count_ff,  count_in;
   addr_type   wp_ff,     wp_in;
   addr_type   rp_ff,     rp_in;
   count_type  rem_ff,    rem_in;
   entry_type  item_ff,   item_in;
   result_type res_ff,    res_in;

   logic       mem_we;
   addr_type   mem_waddr;
   entry_type  mem_wdata;
   addr_type   mem_raddr;
   entry_type  mem_rdata;
   logic       full;

   spq_ram #(
      .ADDR_W (AW),
      .DATA_W ($bits(entry_type)),
      .WORDS  (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign full = (CMP_W'(count_ff) >= CMP_W'(limit)) || (count_ff == count_type'(DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
      wp_ff   <= wp_in;
      rp_ff   <= rp_in;
      rem_ff  <= rem_in;
      item_ff <= item_in;
      res_ff  <= res_in;
   end

   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      rem_in    = rem_ff;
      item_in   = item_ff;
      res_in    = res_ff;
      mem_we    = 1'b0;
      mem_waddr = wp_ff;
      mem_wdata = item_ff;
      mem_raddr = rp_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_kind == KIND_ENQ) begin
                  if (full) begin
                     res_in   = '{status: ST_FULL, head_value: '0, count: count_ff};
                     state_in = S_FIN;
                  end else begin
                     item_in  = '{prio: req_prio, value: req_value};
                     tail_in  = addr_inc(tail_ff);
                     count_in = count_ff + count_type'(1);
                     res_in   = '{status: ST_OK, head_value: '0,
                                  count: count_ff + count_type'(1)};
                     if (count_ff == '0) begin
                        mem_we    = 1'b1;
                        mem_waddr = tail_ff;
                        mem_wdata = '{prio: req_prio, value: req_value};
                        state_in  = S_FIN;
                     end else begin
                        wp_in     = tail_ff;
                        rp_in     = addr_dec(tail_ff);
                        mem_raddr = addr_dec(tail_ff);
                        rem_in    = count_ff;
                        state_in  = S_SCAN;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_in   = '{status: ST_EMPTY, head_value: '0, count: count_ff};
                     state_in = S_FIN;
                  end else begin
                     mem_raddr = head_ff;
                     head_in   = addr_inc(head_ff);
                     count_in  = count_ff - count_type'(1);
                     res_in    = '{status: ST_OK, head_value: '0,
                                   count: count_ff - count_type'(1)};
                     state_in  = S_DEQ;
                  end
               end
            end
         end
         S_DEQ: begin
            res_in.head_value = mem_rdata.value;
            state_in          = S_FIN;
         end
         S_SCAN: begin
            mem_we    = 1'b1;
            mem_waddr = wp_ff;
            if ($signed(item_ff.prio) > $signed(mem_rdata.prio)) begin
               // shift the lower-priority entry one place toward the tail
               mem_wdata = mem_rdata;
               wp_in     = rp_ff;
               rp_in     = addr_dec(rp_ff);
               mem_raddr = addr_dec(rp_ff);
               rem_in    = rem_ff - count_type'(1);
               if (rem_ff == count_type'(1)) begin
                  state_in = S_PLACE;
               end
            end else begin
               mem_wdata = item_ff;
               state_in  = S_FIN;
            end
         end
         S_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = wp_ff;
            mem_wdata = item_ff;
            state_in  = S_FIN;
         end
         S_FIN: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res = res_ff;

endmodule

@@ hdl/sorted_priority_queue.sv @@
// channel  direction  handshake                  payload
// req      in         req_tvalid / req_tready    tuser: kind; tdata: value, priority
// rsp      out        rsp_tvalid / rsp_tready    tuser: status; tdata: head value, count
// csr      in         csr_wr_en                  capacity limit, 7 bits
//
// a refused item and an enqueue into an empty queue go from idle straight to the finish state,
// a dequeue reads the head word first, and any other enqueue first walks the entry ram one word
// a cycle toward the head, moving each entry it passes one place toward the tail
// reset clears the pointers, the count and the result valid flag and sets the limit to 64; no clearing pass
// the result register holds one finished item; a stalled rsp side holds the next
// item in its last state until the register frees
module sorted_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // item_value[31:0], item_priority[63:32]
   input  logic        req_tuser,   // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // head_value[31:0], entry_count[38:32], zero[39]
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);
   import spq_pkg::*;

   logic [LIM_W-1:0] limit_ff;
   logic             rsp_valid_ff;
   result_type       rsp_res_ff;
   logic             res_valid;
   logic             res_ready;
   result_type       res;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tuser),
      .req_value (req_tdata[31:0]),
      .req_prio  (req_tdata[63:32]),
      .limit     (limit_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (res_ready) begin
            rsp_valid_ff <= res_valid;
         end
      end
      if (res_ready && res_valid) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tdata  = {1'b0, 7'(rsp_res_ff.count), rsp_res_ff.head_value};

endmodule
